// ===== rtl/core/alr_pkg.sv =====
// alr_pkg: shared constants, codes and types for the array list block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic              do_insert;
    logic              do_remove;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/alr_stream_if.sv =====
// alr_in_if / alr_out_if: valid/ready channels for operations and results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface alr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  slot_index;
  logic signed [31:0] new_value;

  modport source (output valid, output operation, output slot_index, output new_value,
                  input ready);
  modport sink (input valid, input operation, input slot_index, input new_value,
                output ready);
endinterface

interface alr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink (input valid, input status, input read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/alr_cell.sv =====
// alr_cell: one slot of the list with hold / shift / load selection
// depends on alr_pkg
`timescale 1ns / 1ps
`default_nettype none

module alr_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [alr_pkg::IDX_W-1:0]      cell_idx,
  input  wire alr_pkg::cell_ctrl_t            ctrl,
  input  wire logic [alr_pkg::DATA_W-1:0]     left_in,
  input  wire logic [alr_pkg::DATA_W-1:0]     right_in,
  input  wire logic                           empty_above_in,
  output logic [alr_pkg::DATA_W-1:0]          slot_q,
  output logic                                empty_here_or_above,
  output logic                                empty_here
);

  logic [alr_pkg::DATA_W-1:0] slot_r, slot_nxt;
  logic match, above;

  assign slot_q              = slot_r;
  assign empty_here          = (slot_r == '0);
  // suffix or of empty flags, passed down the row
  assign empty_here_or_above = empty_here | empty_above_in;

  assign match = (cell_idx == ctrl.idx);
  assign above = (cell_idx > ctrl.idx);

  always_comb begin
    slot_nxt = slot_r;
    if (ctrl.do_insert) begin
      if (above && empty_here_or_above) begin
        slot_nxt = left_in;
      end else if (match && empty_here_or_above) begin
        slot_nxt = ctrl.value;
      end
    end else if (ctrl.do_remove) begin
      if (match || above) begin
        slot_nxt = right_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/array_list_insert_remove.sv =====
// array_list_insert_remove: top level, row of slot cells plus result register
// depends on alr_pkg, alr_stream_if, alr_cell
`timescale 1ns / 1ps
`default_nettype none

// A list of DEPTH 32-bit slots (alr_pkg::DEPTH, 16 by default) in which a zero
// slot is empty; the store resets to all empty. Each accepted transaction on
// in_s is one operation (insert, remove, read, or the no-op code) and yields
// exactly one result transaction on out_s with a status and, for a read, the
// slot contents. For each operation every cell of the row picks hold, shift
// or load in the same cycle, steered by an empty-slot flag that ripples down
// the row from the top cell, and the result lands in an output register in
// the cycle after acceptance. One transaction per cycle is sustained;
// in_s.ready drops only while a finished result waits on a stalled out_s.
module array_list_insert_remove (
  input  wire logic clk,
  input  wire logic rst_n,
  alr_in_if.sink    in_s,
  alr_out_if.source out_s
);

  localparam int D = alr_pkg::DEPTH;

  // cell row wiring
  logic [alr_pkg::DATA_W-1:0] slot_w [D];
  logic                       suffix_w [D];
  logic                       empty_w [D];
  alr_pkg::cell_ctrl_t        ctrl;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  alr_pkg::status_t           status_r, status_nxt;
  logic [alr_pkg::DATA_W-1:0] read_r, read_nxt;

  logic                       accept;
  logic                       in_range;
  logic [alr_pkg::IDX_W-1:0]  idx;
  alr_pkg::op_t               op;

  // output register frees up in the same cycle it is taken
  assign in_s.ready = !out_valid_r || out_s.ready;
  assign accept     = in_s.valid && in_s.ready;

  assign op       = alr_pkg::op_t'(in_s.operation);
  assign in_range = (in_s.slot_index < 8'(D));
  assign idx      = in_s.slot_index[alr_pkg::IDX_W-1:0];

  // broadcast control; a remove of an empty slot leaves the row alone
  always_comb begin
    ctrl.idx       = idx;
    ctrl.value     = in_s.new_value;
    ctrl.do_insert = accept && in_range && (op == alr_pkg::OP_INSERT);
    ctrl.do_remove = accept && in_range && (op == alr_pkg::OP_REMOVE) && !empty_w[idx];
  end

  for (genvar j = 0; j < D; j++) begin : g_cell
    logic [alr_pkg::DATA_W-1:0] left_v, right_v;
    logic                       above_v;
    if (j == 0) begin : g_bot
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = slot_w[j-1];
    end
    // top cell shifts in an empty slot on remove; nothing is empty above it
    if (j == D - 1) begin : g_top
      assign right_v = '0;
      assign above_v = 1'b0;
    end else begin : g_mid_r
      assign right_v = slot_w[j+1];
      assign above_v = suffix_w[j+1];
    end

    alr_cell u_cell (
      .clk                 (clk),
      .rst_n               (rst_n),
      .cell_idx            (alr_pkg::IDX_W'(j)),
      .ctrl                (ctrl),
      .left_in             (left_v),
      .right_in            (right_v),
      .empty_above_in      (above_v),
      .slot_q              (slot_w[j]),
      .empty_here_or_above (suffix_w[j]),
      .empty_here          (empty_w[j])
    );
  end

  // status and read data are taken from the cell at the target index
  always_comb begin
    status_nxt    = alr_pkg::ST_OK;
    read_nxt      = '0;
    out_valid_nxt = out_valid_r && !out_s.ready;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (op == alr_pkg::OP_NOP) begin
        status_nxt = alr_pkg::ST_OK;
      end else if (!in_range) begin
        status_nxt = alr_pkg::ST_RANGE;
      end else begin
        case (op)
          alr_pkg::OP_INSERT: begin
            // no empty slot at or above the index means full
            if (!suffix_w[idx]) status_nxt = alr_pkg::ST_FULL;
          end
          alr_pkg::OP_REMOVE: begin
            if (empty_w[idx]) status_nxt = alr_pkg::ST_EMPTY;
          end
          alr_pkg::OP_READ: begin
            read_nxt = slot_w[idx];
          end
          default: begin
            status_nxt = alr_pkg::ST_OK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload loads only on a new transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      read_r   <= read_nxt;
    end
  end

  assign out_s.valid      = out_valid_r;
  assign out_s.status     = status_r;
  assign out_s.read_value = read_r;

endmodule

`default_nettype wire

// ===== rtl/core/alr_checker.sv =====
// alr_checker: port-level assertions for array_list_insert_remove
// depends on alr_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module alr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_operation,
  input wire logic [7:0]  in_slot_index,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_read_value
);

  // pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_read_value))
    else $error("result changed or dropped while stalled");

  // a new result only follows an accepted transaction
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without transaction");

  // a stalled result blocks new input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over stalled result");

  // out-of-range index reports range status with zero data
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation != 2'(alr_pkg::OP_NOP)) &&
    (in_slot_index >= 8'(alr_pkg::DEPTH))
    |=> out_valid && (out_status == 2'(alr_pkg::ST_RANGE)) && (out_read_value == '0))
    else $error("bad out-of-range result");

endmodule

bind array_list_insert_remove alr_checker u_alr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_s.valid),
  .in_ready       (in_s.ready),
  .in_operation   (in_s.operation),
  .in_slot_index  (in_s.slot_index),
  .out_valid      (out_s.valid),
  .out_ready      (out_s.ready),
  .out_status     (out_s.status),
  .out_read_value (out_s.read_value)
);

`default_nettype wire
